FILE: design/tkb_pkg.sv
// Shared types and constants for the top-k sorted insertion buffer.
// No dependencies; compiled first.
`default_nettype none

package tkb_pkg;

   localparam int ID_W             = 32;
   localparam int SCORE_W          = 16;
   localparam int KEEP_W           = 5;
   localparam int SLOT_W           = 4;
   localparam int MAX_KEEP_DEFAULT = 16;

   localparam logic [KEEP_W-1:0]         KEEP_RESET  = 5'd16;
   localparam logic signed [SCORE_W-1:0] EMPTY_SCORE = 16'sh8000;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // word accepted: latch request and slot compares
      logic commit;    // update buffer and load result register
   } tkb_cmd_type;

endpackage

`default_nettype wire

FILE: design/tkb_req_if.sv
// Request channel: valid/ready plus one request word.
// Depends on tkb_pkg.
`default_nettype none

interface tkb_req_if;
   import tkb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [ID_W-1:0]           item_id;
   logic signed [SCORE_W-1:0] item_score;
   logic [SLOT_W-1:0]         slot_index;

   modport source (output valid, output req_type, output item_id, output item_score,
                   output slot_index, input ready);
   modport sink   (input valid, input req_type, input item_id, input item_score,
                   input slot_index, output ready);
endinterface

`default_nettype wire

FILE: design/tkb_rsp_if.sv
// Response channel: valid/ready plus one result word.
// Depends on tkb_pkg.
`default_nettype none

interface tkb_rsp_if;
   import tkb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ID_W-1:0]           best_id;
   logic signed [SCORE_W-1:0] best_score;
   logic [KEEP_W-1:0]         fill_count;
   logic                      was_kept;
   logic [ID_W-1:0]           slot_id;
   logic signed [SCORE_W-1:0] slot_score;

   modport source (output valid, output best_id, output best_score, output fill_count,
                   output was_kept, output slot_id, output slot_score, input ready);
   modport sink   (input valid, input best_id, input best_score, input fill_count,
                   input was_kept, input slot_id, input slot_score, output ready);
endinterface

`default_nettype wire

FILE: design/topk_sorted_insert_buffer_unit.sv
// Top-k sorted insertion buffer: keeps the best MAX_KEEP (id, score) pairs.
// Each accepted request is captured with its slot compares, then committed by the
// shift-insert update into the result register; no new word is accepted until the
// update has committed, and the commit waits while the response side stalls.
// Reset: synchronous; keep count returns to 16 (clamped to MAX_KEEP), buffer empty.
// Depends on tkb_pkg, tkb_req_if, tkb_rsp_if, tkb_ctrl, tkb_datapath.
`default_nettype none

module topk_sorted_insert_buffer_unit #(
   parameter int MAX_KEEP = tkb_pkg::MAX_KEEP_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tkb_req_if.sink                         req_chan,
   tkb_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [tkb_pkg::KEEP_W-1:0] csr_wdata
);
   import tkb_pkg::*;

   tkb_cmd_type cmd;

   tkb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tkb_datapath #(
      .MAX_KEEP (MAX_KEEP)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_type   (req_chan.req_type),
      .item_id    (req_chan.item_id),
      .item_score (req_chan.item_score),
      .slot_index (req_chan.slot_index),
      .best_id    (rsp_chan.best_id),
      .best_score (rsp_chan.best_score),
      .fill_count (rsp_chan.fill_count),
      .was_kept   (rsp_chan.was_kept),
      .slot_id    (rsp_chan.slot_id),
      .slot_score (rsp_chan.slot_score)
   );

endmodule

`default_nettype wire

FILE: design/tkb_ctrl.sv
// Handshake controller: accepts a request word, sequences the buffer update
// and owns the response valid. Depends on tkb_pkg.
`default_nettype none

module tkb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tkb_pkg::tkb_cmd_type   cmd
);
   import tkb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_UPD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      commit;

   assign accept = req_valid && ready_ff;
   // result register must be free or draining this cycle
   assign commit = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in     = (state_in == ST_IDLE);
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.commit  = commit;

endmodule

`default_nettype wire

FILE: design/tkb_datapath.sv
// Slot registers, parallel slot compares, shift-insert update and result
// register. Depends on tkb_pkg.
`default_nettype none

module tkb_datapath #(
   parameter int MAX_KEEP = tkb_pkg::MAX_KEEP_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tkb_pkg::tkb_cmd_type              cmd,
   input  wire logic                              csr_we,
   input  wire logic [tkb_pkg::KEEP_W-1:0]        csr_wdata,
   input  wire logic                              req_type,
   input  wire logic [tkb_pkg::ID_W-1:0]          item_id,
   input  wire logic signed [tkb_pkg::SCORE_W-1:0] item_score,
   input  wire logic [tkb_pkg::SLOT_W-1:0]        slot_index,
   output logic [tkb_pkg::ID_W-1:0]               best_id,
   output logic signed [tkb_pkg::SCORE_W-1:0]     best_score,
   output logic [tkb_pkg::KEEP_W-1:0]             fill_count,
   output logic                                   was_kept,
   output logic [tkb_pkg::ID_W-1:0]               slot_id,
   output logic signed [tkb_pkg::SCORE_W-1:0]     slot_score
);
   import tkb_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int SEL_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   function automatic logic [CNT_W-1:0] clamp_keep(input logic [KEEP_W-1:0] v);
      if (32'(v) > 32'(MAX_KEEP)) return CNT_W'(MAX_KEEP);
      return CNT_W'(v);
   endfunction

   // slot storage (payload, only read below the fill count)
   logic [ID_W-1:0]           id_ff    [MAX_KEEP];
   logic signed [SCORE_W-1:0] score_ff [MAX_KEEP];
   logic [ID_W-1:0]           id_in    [MAX_KEEP];
   logic signed [SCORE_W-1:0] score_in [MAX_KEEP];

   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] filled_ff, filled_in;

   // captured request
   logic [ID_W-1:0]           cand_id_ff;
   logic signed [SCORE_W-1:0] cand_score_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic                      read_ff;
   logic                      kept_ff, kept_in;
   logic [MAX_KEEP-1:0]       ge_ff, ge_in;
   logic [MAX_KEEP-1:0]       in_fill;
   logic                      lt_any;

   // result register
   logic [ID_W-1:0]           best_id_ff, best_id_in;
   logic signed [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [ID_W-1:0]           slot_id_ff, slot_id_in;
   logic signed [SCORE_W-1:0] slot_score_ff, slot_score_in;
   logic [KEEP_W-1:0]         fill_count_ff;
   logic                      was_kept_ff;
   logic                      slot_hit;
   logic [SEL_W-1:0]          slot_sel;

   // filled slots at or above the candidate score; a thermometer from slot 0
   always_comb begin
      for (int i = 0; i < MAX_KEEP; i++) begin
         in_fill[i] = 32'(i) < 32'(filled_ff);
         ge_in[i]   = in_fill[i] && (score_ff[i] >= item_score);
      end
      lt_any  = |(in_fill & ~ge_in);
      kept_in = (req_type == REQ_INSERT) && (keep_ff != '0) &&
                ((filled_ff < keep_ff) || lt_any);
   end

   // each slot either holds, takes the candidate, or takes its upper neighbor
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_slot
      logic [ID_W-1:0]           up_id;
      logic signed [SCORE_W-1:0] up_score;
      logic                      move;

      if (g == 0) begin : g_top
         assign up_id    = cand_id_ff;
         assign up_score = cand_score_ff;
      end else begin : g_rest
         assign up_id    = ge_ff[g-1] ? cand_id_ff    : id_ff[g-1];
         assign up_score = ge_ff[g-1] ? cand_score_ff : score_ff[g-1];
      end

      assign move = cmd.commit && kept_ff && !ge_ff[g] && (32'(g) < 32'(keep_ff));
      assign id_in[g]    = move ? up_id    : id_ff[g];
      assign score_in[g] = move ? up_score : score_ff[g];
   end

   always_comb begin
      keep_in   = keep_ff;
      filled_in = filled_ff;
      if (csr_we) begin
         keep_in   = clamp_keep(csr_wdata);
         filled_in = '0;
      end else if (cmd.commit && kept_ff && (filled_ff < keep_ff)) begin
         filled_in = filled_ff + CNT_W'(1);
      end
   end

   always_comb begin
      best_id_in    = '0;
      best_score_in = EMPTY_SCORE;
      if (filled_in != '0) begin
         best_id_in    = id_in[0];
         best_score_in = score_in[0];
      end
      slot_hit = read_ff && (32'(slot_ff) < 32'(MAX_KEEP)) &&
                 (32'(slot_ff) < 32'(filled_ff));
      slot_sel      = SEL_W'(slot_ff);
      slot_id_in    = '0;
      slot_score_in = EMPTY_SCORE;
      if (slot_hit) begin
         slot_id_in    = id_ff[slot_sel];
         slot_score_in = score_ff[slot_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff   <= clamp_keep(KEEP_RESET);
         filled_ff <= '0;
      end else begin
         keep_ff   <= keep_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
         id_ff[i]    <= id_in[i];
         score_ff[i] <= score_in[i];
      end
      if (cmd.capture) begin
         cand_id_ff    <= item_id;
         cand_score_ff <= item_score;
         slot_ff       <= slot_index;
         read_ff       <= (req_type == REQ_READ);
         kept_ff       <= kept_in;
         ge_ff         <= ge_in;
      end
      if (cmd.commit) begin
         best_id_ff    <= best_id_in;
         best_score_ff <= best_score_in;
         fill_count_ff <= KEEP_W'(filled_in);
         was_kept_ff   <= kept_ff;
         slot_id_ff    <= slot_id_in;
         slot_score_ff <= slot_score_in;
      end
   end

   assign best_id    = best_id_ff;
   assign best_score = best_score_ff;
   assign fill_count = fill_count_ff;
   assign was_kept   = was_kept_ff;
   assign slot_id    = slot_id_ff;
   assign slot_score = slot_score_ff;

endmodule

`default_nettype wire

FILE: design/tkb_checker.sv
// Port-level checks on the response channel, bound to the top level.
// Depends on tkb_pkg and topk_sorted_insert_buffer_unit.
`default_nettype none

module tkb_checker #(
   parameter int MAX_KEEP = tkb_pkg::MAX_KEEP_DEFAULT
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [tkb_pkg::ID_W-1:0]          best_id,
   input wire logic signed [tkb_pkg::SCORE_W-1:0] best_score,
   input wire logic [tkb_pkg::KEEP_W-1:0]        fill_count,
   input wire logic                              was_kept,
   input wire logic [tkb_pkg::ID_W-1:0]          slot_id,
   input wire logic signed [tkb_pkg::SCORE_W-1:0] slot_score
);
   import tkb_pkg::*;

   // a pending word is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(fill_count) <= 32'(MAX_KEEP)) || (MAX_KEEP > 31))
      else $error("fill count beyond buffer depth");

   a_empty_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (fill_count == '0) && (MAX_KEEP < 32) |->
         (best_id == '0) && (best_score == EMPTY_SCORE))
      else $error("empty buffer reports a best entry");

   a_kept_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_kept && (MAX_KEEP < 32) |-> (fill_count != '0))
      else $error("kept insert leaves buffer empty");

   // kept inserts carry empty slot fields
   a_kept_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_kept |-> (slot_id == '0) && (slot_score == EMPTY_SCORE))
      else $error("insert response carries slot data");

endmodule

bind topk_sorted_insert_buffer_unit tkb_checker #(
   .MAX_KEEP (MAX_KEEP)
) u_tkb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .best_id    (rsp_chan.best_id),
   .best_score (rsp_chan.best_score),
   .fill_count (rsp_chan.fill_count),
   .was_kept   (rsp_chan.was_kept),
   .slot_id    (rsp_chan.slot_id),
   .slot_score (rsp_chan.slot_score)
);

`default_nettype wire

FILE: tb/topk_sorted_insert_buffer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking test of the top-k sorted insertion buffer: a shadow copy of the
// buffer predicts every response word, which is compared field by field.
// Depends on tkb_pkg, tkb_req_if, tkb_rsp_if and topk_sorted_insert_buffer_unit.

module topk_sorted_insert_buffer_unit_test;
   import tkb_pkg::*;

   localparam int DEPTH = 16;

   typedef struct {
      logic                      req_type;
      logic [ID_W-1:0]           item_id;
      logic signed [SCORE_W-1:0] item_score;
      logic [SLOT_W-1:0]         slot_index;
   } request_type;

   typedef struct {
      logic [ID_W-1:0]           best_id;
      logic signed [SCORE_W-1:0] best_score;
      logic [KEEP_W-1:0]         fill_count;
      logic                      was_kept;
      logic [ID_W-1:0]           slot_id;
      logic signed [SCORE_W-1:0] slot_score;
   } status_type;

   // Shadow buffer plus the queue of status words it has predicted.
   class topk_shadow_type;
      logic [ID_W-1:0]           ids[DEPTH];
      logic signed [SCORE_W-1:0] scores[DEPTH];
      int                        filled;
      int                        keep;
      status_type                pending_status[$];
      int                        errors;
      int                        checked;
      int                        kept;
      int                        dropped;
      int                        reads;

      function void clear_entries();
         for (int i = 0; i < DEPTH; i++) begin
            ids[i]    = '0;
            scores[i] = EMPTY_SCORE;
         end
         filled = 0;
      endfunction

      function void set_keep(logic [KEEP_W-1:0] value);
         keep = (value > DEPTH) ? DEPTH : int'(value);
         clear_entries();
      endfunction

      function void note_request(request_type r);
         status_type s;
         int         pos;
         int         i;
         s.was_kept   = 1'b0;
         s.slot_id    = '0;
         s.slot_score = EMPTY_SCORE;
         if (r.req_type == REQ_INSERT) begin
            pos = 0;
            for (i = 0; i < keep; i++)
               if (i < filled && scores[i] >= r.item_score)
                  pos++;
            if (keep != 0 && pos < keep) begin
               for (i = keep - 1; i > pos; i--) begin
                  ids[i]    = ids[i-1];
                  scores[i] = scores[i-1];
               end
               ids[pos]    = r.item_id;
               scores[pos] = r.item_score;
               if (filled < keep)
                  filled++;
               s.was_kept = 1'b1;
               kept++;
            end else begin
               dropped++;
            end
         end else begin
            reads++;
            if (int'(r.slot_index) < filled) begin
               s.slot_id    = ids[r.slot_index];
               s.slot_score = scores[r.slot_index];
            end
         end
         s.best_id    = (filled > 0) ? ids[0] : '0;
         s.best_score = (filled > 0) ? scores[0] : EMPTY_SCORE;
         s.fill_count = KEEP_W'(filled);
         pending_status.push_back(s);
      endfunction

      task report_mismatch(string field, longint got, longint want);
         $display("[%0t] mismatch on word %0d, %s: got %0d, expected %0d",
                  $time, checked, field, got, want);
         errors++;
      endtask

      task check_status(status_type got);
         status_type want;
         if (pending_status.size() == 0) begin
            $display("[%0t] response word with nothing outstanding", $time);
            errors++;
         end else begin
            want = pending_status.pop_front();
            if (got.best_id !== want.best_id)
               report_mismatch("best_id", got.best_id, want.best_id);
            if (got.best_score !== want.best_score)
               report_mismatch("best_score", got.best_score, want.best_score);
            if (got.fill_count !== want.fill_count)
               report_mismatch("fill_count", got.fill_count, want.fill_count);
            if (got.was_kept !== want.was_kept)
               report_mismatch("was_kept", got.was_kept, want.was_kept);
            if (got.slot_id !== want.slot_id)
               report_mismatch("slot_id", got.slot_id, want.slot_id);
            if (got.slot_score !== want.slot_score)
               report_mismatch("slot_score", got.slot_score, want.slot_score);
         end
         checked++;
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [KEEP_W-1:0]   csr_wdata;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  keep_writes;
   topk_shadow_type     shadow = new;

   tkb_req_if req_chan ();
   tkb_rsp_if rsp_chan ();

   topk_sorted_insert_buffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: check on the handshake, then pick next cycle's ready
   always @(posedge clock) begin
      status_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.best_id    = rsp_chan.best_id;
         got.best_score = rsp_chan.best_score;
         got.fill_count = rsp_chan.fill_count;
         got.was_kept   = rsp_chan.was_kept;
         got.slot_id    = rsp_chan.slot_id;
         got.slot_score = rsp_chan.slot_score;
         shadow.check_status(got);
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // leaves valid high on return; drain_results lowers it when stimulus pauses
   task automatic send_word(request_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= w.req_type;
      req_chan.item_id    <= w.item_id;
      req_chan.item_score <= w.item_score;
      req_chan.slot_index <= w.slot_index;
      do
         @(posedge clock);
      while (!req_chan.ready);
      shadow.note_request(w);
   endtask

   task automatic send_insert(logic [ID_W-1:0] id, logic signed [SCORE_W-1:0] score);
      request_type w;
      w.req_type   = REQ_INSERT;
      w.item_id    = id;
      w.item_score = score;
      w.slot_index = SLOT_W'($urandom);
      send_word(w);
   endtask

   task automatic send_read(logic [SLOT_W-1:0] slot);
      request_type w;
      w.req_type   = REQ_READ;
      w.item_id    = $urandom;
      w.item_score = SCORE_W'($urandom);
      w.slot_index = slot;
      send_word(w);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (shadow.pending_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_keep(logic [KEEP_W-1:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.set_keep(value);
      keep_writes++;
   endtask

   // mix of full-range scores, extremes and a narrow band that forces ties
   function automatic logic signed [SCORE_W-1:0] pick_score();
      logic signed [SCORE_W-1:0] extremes[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
                                                 -16'sd1, 16'sd1};
      unique case ($urandom_range(3))
         0, 1: return SCORE_W'($urandom);
         2: return extremes[$urandom_range(4)];
         default: return SCORE_W'(int'($urandom_range(8)) - 4);
      endcase
   endfunction

   task automatic run_random(int count, bit hold_midway);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 70)
            send_insert($urandom, pick_score());
         else
            send_read(SLOT_W'($urandom_range(15)));
         if (hold_midway && n == count / 2)
            drain_results();
      end
   endtask

   initial begin
      logic [KEEP_W-1:0] keep_plan[12] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd16,
                                           5'd17, 5'd2, 5'd12, 5'd16, 5'd6, 5'd15};
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= REQ_INSERT;
      req_chan.item_id   <= '0;
      req_chan.item_score <= '0;
      req_chan.slot_index <= '0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      keep_writes        = 0;
      shadow.set_keep(KEEP_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, extremes, ties, drops at a small k, k of zero
      send_read(4'd0);
      send_read(4'd15);
      send_insert(32'hFFFF_FFFF, 16'sh7FFF);
      send_insert(32'h0000_0000, 16'sh8000);
      send_insert(32'h1234_5678, 16'sh7FFF);   // tie goes after the equal entry
      send_insert(32'hA5A5_5A5A, 16'sh0000);
      send_insert(32'h5A5A_A5A5, -16'sd1);
      send_read(4'd0);
      send_read(4'd1);
      send_read(4'd4);
      send_read(4'd5);                         // one past the fill count
      write_keep(5'd2);
      send_insert(32'h0000_0011, 16'sd100);
      send_insert(32'h0000_0022, 16'sd200);
      send_insert(32'h0000_0033, 16'sd100);    // ties the last slot, dropped
      send_insert(32'h0000_0044, 16'sh8000);
      send_insert(32'h0000_0055, 16'sd300);
      send_read(4'd1);
      write_keep(5'd0);
      send_insert(32'hDEAD_BEEF, 16'sh7FFF);   // ignored
      send_read(4'd0);
      write_keep(5'd31);                       // saturates
      send_insert(32'h0BAD_F00D, 16'sh4000);
      send_read(4'd0);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 62 : 0;
         recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 8 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            write_keep(keep_plan[ph*4 + seg]);
            run_random(62, ph == 0 && seg == 1);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Checked %0d response words: %0d inserts kept, %0d dropped, %0d slot reads,",
               shadow.checked, shadow.kept, shadow.dropped, shadow.reads);
      $display("over %0d keep-count settings and three sender/receiver stall mixes.",
               keep_writes);
      if (shadow.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #400000;
      $display("[%0t] timeout with %0d words outstanding", $time,
               shadow.pending_status.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
